// ===== sv/pidvi_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pidvi_pkg: shared types and microcode for the variable-integral PID
// Register indexes, control word layout and the sequencer program.
// ============================================================================
package pidvi_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 24;
    localparam int THR_W    = 15;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int WGT_W    = 17;
    localparam int OUT_W    = 32;
    localparam int MUL_A_W  = GAIN_W + 1;
    localparam int MUL_B_W  = OUT_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int FRAC_SH  = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = GAIN_W;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_ABS_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_ABS_MIN = 3'd5;

    localparam logic [SAMPLE_W-1:0] RST_SETPOINT    = 16'd17920;
    localparam logic [GAIN_W-1:0]   RST_PROP_GAIN   = 24'd4096000;
    localparam logic [GAIN_W-1:0]   RST_INTEG_GAIN  = 24'd204800;
    localparam logic [GAIN_W-1:0]   RST_DERIV_GAIN  = 24'd819;
    localparam logic [THR_W-1:0]    RST_ERR_ABS_MAX = 15'd230;
    localparam logic [THR_W-1:0]    RST_ERR_ABS_MIN = 15'd26;

    localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CLASS = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DIV   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MULW  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_INTEG = 4'd4;
    localparam logic [STEP_W-1:0] STEP_MULP  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_MULI  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MULD  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SUBD  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd9;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLASS,
        OP_DIV,
        OP_INTEG,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [1:0] {
        MUL_W,
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_IN,
        BR_CLS,
        BR_DIV,
        BR_OUT,
        BR_JMP
    } t_br;

    typedef struct packed {
        t_dp_op             op;
        t_mul_sel           mul;
        t_acc_op            acc;
        t_br                br;
        logic [STEP_W-1:0]  target;
    } t_uop;

    typedef struct packed {
        logic in_fire;
        logic w_clamp;
        logic div_last;
        logic out_free;
    } t_cond;

    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{op: OP_NONE, mul: MUL_W, acc: ACC_HOLD, br: BR_NEXT, target: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                u.op = OP_LOAD;
                u.br = BR_IN;
            end
            STEP_CLASS: begin
                u.op     = OP_CLASS;
                u.br     = BR_CLS;
                u.target = STEP_MULW;
            end
            STEP_DIV: begin
                u.op = OP_DIV;
                u.br = BR_DIV;
            end
            STEP_MULW: begin
                u.mul = MUL_W;
            end
            STEP_INTEG: begin
                u.op = OP_INTEG;
            end
            STEP_MULP: begin
                u.mul = MUL_P;
            end
            STEP_MULI: begin
                u.mul = MUL_I;
                u.acc = ACC_LOAD;
            end
            STEP_MULD: begin
                u.mul = MUL_D;
                u.acc = ACC_ADD;
            end
            STEP_SUBD: begin
                u.acc = ACC_SUB;
            end
            STEP_EMIT: begin
                u.op     = OP_EMIT;
                u.br     = BR_OUT;
                u.target = STEP_IDLE;
            end
            default: begin
                u.br     = BR_JMP;
                u.target = STEP_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

// ===== sv/pidvi_in_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pidvi_in_if: sample channel
// Valid/ready channel carrying one measured sample per word.
// ============================================================================
interface pidvi_in_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  process_value;

    modport source (output valid, output process_value, input ready);
    modport sink   (input valid, input process_value, output ready);
endinterface

// ===== sv/pidvi_out_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pidvi_out_if: drive channel
// Valid/ready channel carrying one controller output per word.
// ============================================================================
interface pidvi_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  drive_output;

    modport source (output valid, output drive_output, input ready);
    modport sink   (input valid, input drive_output, output ready);
endinterface

// ===== sv/positional_pid_variable_integral.sv =====
// Sample accept to output valid runs through CLASS, MULW, INTEG, MULP, MULI,
// MULD, SUBD and EMIT when the error is at or below the low threshold or above
// the high one; on the ramp a restoring divide for the weight runs in DIV first.
// One sample in flight at a time; the next is accepted the cycle after the output word is loaded.
// Synchronous active-low reset restores register defaults, clears the integral
// and last sample, and empties the output register.
`timescale 1ns / 1ps
// ============================================================================
// positional_pid_variable_integral: positional PID, variable integral weight
// Microcoded datapath: one shared 25x33 multiplier, accumulator, bit divider.
// ============================================================================
module positional_pid_variable_integral
    import pidvi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pidvi_in_if.sink              i_sample_if,
    pidvi_out_if.source           o_drive_if,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_wdata
);

    // configuration
    logic [SAMPLE_W-1:0] r_setpoint;
    logic [GAIN_W-1:0]   r_prop_gain;
    logic [GAIN_W-1:0]   r_integ_gain;
    logic [GAIN_W-1:0]   r_deriv_gain;
    logic [THR_W-1:0]    r_err_abs_max;
    logic [THR_W-1:0]    r_err_abs_min;

    // state
    logic [OUT_W-1:0]    r_integral;
    logic [SAMPLE_W-1:0] r_last;

    // datapath
    logic [SAMPLE_W-1:0]      r_pv;
    logic [ERR_W-1:0]         r_e;
    logic [SAMPLE_W-1:0]      r_mag;
    logic [WGT_W-1:0]         r_w;
    logic [THR_W-1:0]         r_rem;
    logic [THR_W-1:0]         r_div;
    logic [DIV_CNT_W-1:0]     r_div_cnt;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_out_data;

    t_uop  uop;
    t_cond cond;

    logic                     in_fire;
    logic                     out_free;
    logic                     emit_fire;
    logic [ERR_W-1:0]         err_in;
    logic [ERR_W-1:0]         err_neg;
    logic [SAMPLE_W-1:0]      mag_in;
    logic                     w_full;
    logic                     w_zero;
    logic [SAMPLE_W:0]        div_diff;
    logic [ERR_W-1:0]         diff_pv;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [SAMPLE_W-1:0]      wmag;
    logic [ERR_W-1:0]         werr;
    logic [OUT_W:0]           isum;
    logic [OUT_W-1:0]         isum_sat;
    logic [PROD_W-1:0]        acc_bias;
    logic [PROD_W-1:0]        acc_rnd;
    logic [PROD_W-FRAC_SH-1:0] quot;
    logic [PROD_W-FRAC_SH-OUT_W:0] quot_hi;
    logic [OUT_W-1:0]         out_sat;

    pidvi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_uop   (uop)
    );

    assign i_sample_if.ready = (uop.br == BR_IN);
    assign in_fire   = i_sample_if.valid && i_sample_if.ready;
    assign out_free  = !r_out_valid || o_drive_if.ready;
    assign emit_fire = (uop.op == OP_EMIT) && out_free;

    assign o_drive_if.valid        = r_out_valid;
    assign o_drive_if.drive_output = r_out_data;

    // error and magnitude of the incoming sample
    assign err_in  = {r_setpoint[SAMPLE_W-1], r_setpoint}
                   - {i_sample_if.process_value[SAMPLE_W-1], i_sample_if.process_value};
    assign err_neg = -err_in;
    assign mag_in  = err_in[ERR_W-1] ? err_neg[SAMPLE_W-1:0] : err_in[SAMPLE_W-1:0];

    assign w_full = (r_mag <= {1'b0, r_err_abs_min});
    assign w_zero = (r_mag >  {1'b0, r_err_abs_max});

    assign cond.in_fire  = in_fire;
    assign cond.w_clamp  = w_full || w_zero;
    assign cond.div_last = (r_div_cnt == DIV_LAST);
    assign cond.out_free = out_free;

    // restoring divide, one quotient bit per step
    assign div_diff = {1'b0, r_rem, 1'b0} - {2'b00, r_div};

    assign diff_pv = {r_pv[SAMPLE_W-1], r_pv} - {r_last[SAMPLE_W-1], r_last};

    always_comb begin
        case (uop.mul)
            MUL_W: begin
                mul_a = {{(MUL_A_W-WGT_W){1'b0}}, r_w};
                mul_b = {{(MUL_B_W-SAMPLE_W){1'b0}}, r_mag};
            end
            MUL_P: begin
                mul_a = {1'b0, r_prop_gain};
                mul_b = {{(MUL_B_W-ERR_W){r_e[ERR_W-1]}}, r_e};
            end
            MUL_I: begin
                mul_a = {1'b0, r_integ_gain};
                mul_b = {r_integral[OUT_W-1], r_integral};
            end
            MUL_D: begin
                mul_a = {1'b0, r_deriv_gain};
                mul_b = {{(MUL_B_W-ERR_W){diff_pv[ERR_W-1]}}, diff_pv};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // weighted error, truncated toward zero, into the saturating integral
    assign wmag = r_prod[2*SAMPLE_W-1:SAMPLE_W];
    assign werr = r_e[ERR_W-1] ? -{1'b0, wmag} : {1'b0, wmag};
    assign isum = {r_integral[OUT_W-1], r_integral}
                + {{(OUT_W+1-ERR_W){werr[ERR_W-1]}}, werr};
    assign isum_sat = (isum[OUT_W] != isum[OUT_W-1])
                    ? {isum[OUT_W], {(OUT_W-1){~isum[OUT_W]}}}
                    : isum[OUT_W-1:0];

    // Q.20 sum to Q.8, truncated toward zero, then saturated
    assign acc_bias = r_acc[PROD_W-1] ? PROD_W'((1 << FRAC_SH) - 1) : '0;
    assign acc_rnd  = r_acc + acc_bias;
    assign quot     = acc_rnd[PROD_W-1:FRAC_SH];
    assign quot_hi  = quot[PROD_W-FRAC_SH-1:OUT_W-1];
    assign out_sat  = ((quot_hi == '0) || (quot_hi == '1))
                    ? quot[OUT_W-1:0]
                    : {quot[PROD_W-FRAC_SH-1], {(OUT_W-1){~quot[PROD_W-FRAC_SH-1]}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint    <= RST_SETPOINT;
            r_prop_gain   <= RST_PROP_GAIN;
            r_integ_gain  <= RST_INTEG_GAIN;
            r_deriv_gain  <= RST_DERIV_GAIN;
            r_err_abs_max <= RST_ERR_ABS_MAX;
            r_err_abs_min <= RST_ERR_ABS_MIN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SETPOINT:    r_setpoint    <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_wdata[GAIN_W-1:0];
                CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_wdata[GAIN_W-1:0];
                CFG_ERR_ABS_MAX: r_err_abs_max <= i_cfg_wdata[THR_W-1:0];
                CFG_ERR_ABS_MIN: r_err_abs_min <= i_cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral  <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (uop.op == OP_INTEG) begin
                r_integral <= isum_sat;
            end
            if (emit_fire) begin
                r_last      <= r_pv;
                r_out_valid <= 1'b1;
            end else if (o_drive_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        case (uop.acc)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            ACC_SUB:  r_acc <= r_acc - r_prod;
            default:  ;
        endcase

        case (uop.op)
            OP_LOAD: begin
                if (in_fire) begin
                    r_pv  <= i_sample_if.process_value;
                    r_e   <= err_in;
                    r_mag <= mag_in;
                end
            end
            OP_CLASS: begin
                r_w       <= w_full ? WGT_ONE : '0;
                r_rem     <= r_err_abs_max - r_mag[THR_W-1:0];
                r_div     <= r_err_abs_max - r_err_abs_min;
                r_div_cnt <= '0;
            end
            OP_DIV: begin
                r_w       <= {r_w[WGT_W-2:0], ~div_diff[SAMPLE_W]};
                r_rem     <= div_diff[SAMPLE_W] ? {r_rem[THR_W-2:0], 1'b0}
                                                : div_diff[THR_W-1:0];
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            OP_EMIT: begin
                if (emit_fire) begin
                    r_out_data <= out_sat;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/pidvi_seq.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pidvi_seq: microcode sequencer
// Step counter and control store; picks the next step from branch conditions.
// ============================================================================
module pidvi_seq
    import pidvi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cond i_cond,
    output t_uop  o_uop
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [STEP_W-1:0] step_inc;

    assign o_uop    = uop_rom(r_step);
    assign step_inc = r_step + 1'b1;

    always_comb begin
        case (o_uop.br)
            BR_NEXT: n_step = step_inc;
            BR_IN:   n_step = i_cond.in_fire  ? step_inc     : r_step;
            BR_CLS:  n_step = i_cond.w_clamp  ? o_uop.target : step_inc;
            BR_DIV:  n_step = i_cond.div_last ? step_inc     : r_step;
            BR_OUT:  n_step = i_cond.out_free ? o_uop.target : r_step;
            BR_JMP:  n_step = o_uop.target;
            default: n_step = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== sv/pidvi_chk.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pidvi_chk: port-level checks for the variable-integral PID
// Reset state, one sample in flight, result word present when the sample port reopens, output word held while stalled.
// ============================================================================
module pidvi_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data
);

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("not idle and empty after reset");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second sample accepted while one is in work");

    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_in_ready) |-> i_out_valid)
        else $error("sample port reopened without a result word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled output word dropped or changed");

endmodule

bind positional_pid_variable_integral pidvi_chk u_pidvi_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample_if.valid),
    .i_in_ready  (i_sample_if.ready),
    .i_out_valid (o_drive_if.valid),
    .i_out_ready (o_drive_if.ready),
    .i_out_data  (o_drive_if.drive_output)
);
